@@ sv/jps_pkg.sv @@
// Shared types, character codes and literal tables for the JSON pair scanner.
// No dependencies; every other file imports this package.
package jps_pkg;

  localparam int POS_W = 12;
  localparam int BYTE_W = 8;
  localparam int COUNT_W = 8;
  localparam int DEF_MAX_DOC_BYTES = 4096;
  localparam int QUEUE_DEPTH = 4;

  typedef logic [POS_W-1:0] pos_t;
  typedef logic [BYTE_W-1:0] byte_t;
  typedef logic [COUNT_W-1:0] count_t;

  localparam count_t MAX_PAIRS_RESET = 8'd16;
  localparam count_t COUNT_MAX = 8'hFF;

  localparam logic RK_PAIR = 1'b0;
  localparam logic RK_SUMMARY = 1'b1;

  typedef enum logic [2:0] {
    VT_NULL = 3'd0,
    VT_BOOL = 3'd1,
    VT_STRING = 3'd2,
    VT_NUMBER = 3'd3,
    VT_UNKNOWN = 3'd4
  } vtype_t;

  typedef enum logic [2:0] {
    PH_SEEK_KEY,
    PH_IN_KEY,
    PH_SEEK_COLON,
    PH_SKIP_WS,
    PH_IN_QUOTED,
    PH_IN_LITERAL,
    PH_IN_BARE
  } phase_t;

  typedef enum logic [1:0] {
    LIT_NONE,
    LIT_NULL,
    LIT_TRUE,
    LIT_FALSE
  } lit_t;

  localparam byte_t CH_NUL = 8'h00;
  localparam byte_t CH_TAB = 8'h09;
  localparam byte_t CH_LF = 8'h0A;
  localparam byte_t CH_CR = 8'h0D;
  localparam byte_t CH_SPACE = 8'h20;
  localparam byte_t CH_QUOTE = 8'h22;
  localparam byte_t CH_COMMA = 8'h2C;
  localparam byte_t CH_MINUS = 8'h2D;
  localparam byte_t CH_DIGIT0 = 8'h30;
  localparam byte_t CH_DIGIT9 = 8'h39;
  localparam byte_t CH_COLON = 8'h3A;
  localparam byte_t CH_RBRACE = 8'h7D;

  typedef struct packed {
    logic   record_kind;
    pos_t   key_offset;
    pos_t   key_length;
    pos_t   value_offset;
    pos_t   value_length;
    vtype_t value_type;
    count_t pair_count;
    logic   last;
  } record_t;

  typedef struct packed {
    logic [1:0] n;
    record_t    rec_a;
    record_t    rec_b;
  } scan_out_t;

  function automatic logic [2:0] lit_len(input lit_t cand);
    case (cand)
      LIT_NULL: return 3'd4;
      LIT_TRUE: return 3'd4;
      LIT_FALSE: return 3'd5;
      default: return 3'd0;
    endcase
  endfunction

  function automatic byte_t lit_char(input lit_t cand, input logic [2:0] idx);
    byte_t ch;
    ch = CH_NUL;
    case (cand)
      LIT_NULL: begin
        case (idx)
          3'd0: ch = "n";
          3'd1: ch = "u";
          3'd2: ch = "l";
          3'd3: ch = "l";
          default: ch = CH_NUL;
        endcase
      end
      LIT_TRUE: begin
        case (idx)
          3'd0: ch = "t";
          3'd1: ch = "r";
          3'd2: ch = "u";
          3'd3: ch = "e";
          default: ch = CH_NUL;
        endcase
      end
      LIT_FALSE: begin
        case (idx)
          3'd0: ch = "f";
          3'd1: ch = "a";
          3'd2: ch = "l";
          3'd3: ch = "s";
          3'd4: ch = "e";
          default: ch = CH_NUL;
        endcase
      end
      default: ch = CH_NUL;
    endcase
    return ch;
  endfunction

  function automatic lit_t lit_start(input byte_t c);
    if (c == "n") return LIT_NULL;
    if (c == "t") return LIT_TRUE;
    if (c == "f") return LIT_FALSE;
    return LIT_NONE;
  endfunction

  function automatic logic lit_is(input lit_t cand, input logic [2:0] cnt, input pos_t size,
                                  input lit_t want);
    return (cand == want) && (cnt == lit_len(want)) && (size == pos_t'(lit_len(want)));
  endfunction

  function automatic vtype_t value_kind(input lit_t cand, input logic [2:0] cnt,
                                        input pos_t size, input byte_t first,
                                        input logic quoted);
    if (lit_is(cand, cnt, size, LIT_NULL)) return VT_NULL;
    if (lit_is(cand, cnt, size, LIT_TRUE) || lit_is(cand, cnt, size, LIT_FALSE)) return VT_BOOL;
    if (size != '0 && quoted) return VT_STRING;
    if ((first >= CH_DIGIT0 && first <= CH_DIGIT9) || first == CH_MINUS) return VT_NUMBER;
    return VT_UNKNOWN;
  endfunction

endpackage

@@ sv/jps_if.sv @@
// Valid/ready channel interfaces: text bytes in, pair records out.
// Depends on jps_pkg.
interface jps_text_if;
  import jps_pkg::*;
  logic  valid;
  logic  ready;
  byte_t text_byte;
  modport source (output valid, output text_byte, input ready);
  modport sink (input valid, input text_byte, output ready);
endinterface

interface jps_record_if;
  import jps_pkg::*;
  logic   valid;
  logic   ready;
  logic   record_kind;
  pos_t   key_offset;
  pos_t   key_length;
  pos_t   value_offset;
  pos_t   value_length;
  vtype_t value_type;
  count_t pair_count;
  logic   last;
  modport source (output valid, output record_kind, output key_offset, output key_length,
                  output value_offset, output value_length, output value_type,
                  output pair_count, output last, input ready);
  modport sink (input valid, input record_kind, input key_offset, input key_length,
                input value_offset, input value_length, input value_type,
                input pair_count, input last, output ready);
endinterface

@@ sv/jps_scan.sv @@
// Per-byte scan state and step logic; produces up to two records per byte.
// Depends on jps_pkg.
module jps_scan #(
  parameter int MAX_DOC_BYTES = jps_pkg::DEF_MAX_DOC_BYTES
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               accept,
  input  jps_pkg::byte_t     text_byte,
  input  logic               cfg_we,
  input  jps_pkg::count_t    cfg_data,
  output jps_pkg::scan_out_t emit
);
  import jps_pkg::*;

  localparam int PosCap = (1 << POS_W) - 1;
  localparam int PosLimitInt = (MAX_DOC_BYTES - 1 < PosCap) ? MAX_DOC_BYTES - 1 : PosCap;
  localparam pos_t PosLimit = pos_t'(PosLimitInt);

  phase_t     phase, phase_next;
  pos_t       byte_position, byte_position_next;
  pos_t       key_start, key_start_next;
  pos_t       key_size, key_size_next;
  pos_t       value_start, value_start_next;
  pos_t       value_size, value_size_next;
  lit_t       lit_cand, lit_cand_next;
  logic [2:0] lit_cnt, lit_cnt_next;
  byte_t      first_char, first_char_next;
  count_t     pairs_seen, pairs_seen_next;
  count_t     max_pairs;

  logic    end_doc;
  logic    pair_hit;
  logic    pair_quoted;
  logic    is_term;
  logic    is_ws;
  logic    lit_ok;
  lit_t    cand_new;
  count_t  pairs_emit;
  record_t pair_rec;
  record_t sum_rec;

  function automatic pos_t sat_inc(input pos_t v);
    return (v < PosLimit) ? v + pos_t'(1) : v;
  endfunction

  assign end_doc = (text_byte == CH_NUL);
  assign is_term = (text_byte == CH_COMMA) || (text_byte == CH_RBRACE) ||
                   (text_byte == CH_SPACE) || (text_byte == CH_LF) || (text_byte == CH_CR);
  assign is_ws = (text_byte == CH_SPACE) || (text_byte == CH_TAB) ||
                 (text_byte == CH_LF) || (text_byte == CH_CR);
  assign lit_ok = (lit_cand != LIT_NONE) && (lit_cnt < lit_len(lit_cand)) &&
                  (text_byte == lit_char(lit_cand, lit_cnt));
  assign cand_new = lit_start(text_byte);

  always_comb begin
    phase_next = phase;
    byte_position_next = sat_inc(byte_position);
    key_start_next = key_start;
    key_size_next = key_size;
    value_start_next = value_start;
    value_size_next = value_size;
    lit_cand_next = lit_cand;
    lit_cnt_next = lit_cnt;
    first_char_next = first_char;
    pair_hit = 1'b0;
    pair_quoted = 1'b0;

    if (end_doc) begin
      if (phase == PH_SKIP_WS) begin
        value_start_next = byte_position;
        value_size_next = '0;
        first_char_next = CH_NUL;
        lit_cand_next = LIT_NONE;
        lit_cnt_next = '0;
        pair_hit = 1'b1;
      end else if (phase == PH_IN_LITERAL || phase == PH_IN_BARE) begin
        lit_cand_next = LIT_NONE;
        lit_cnt_next = '0;
        pair_hit = 1'b1;
      end
    end else begin
      case (phase)
        PH_IN_KEY: begin
          if (text_byte == CH_QUOTE) begin
            phase_next = PH_SEEK_COLON;
          end else begin
            key_size_next = sat_inc(key_size);
          end
        end
        PH_SEEK_COLON: begin
          if (text_byte == CH_COLON) begin
            phase_next = PH_SKIP_WS;
          end
        end
        PH_SKIP_WS: begin
          if (is_ws) begin
            phase_next = PH_SKIP_WS;
          end else if (text_byte == CH_QUOTE) begin
            value_start_next = sat_inc(byte_position);
            value_size_next = '0;
            first_char_next = CH_QUOTE;
            lit_cand_next = LIT_NONE;
            lit_cnt_next = '0;
            phase_next = PH_IN_QUOTED;
          end else begin
            value_start_next = byte_position;
            first_char_next = text_byte;
            lit_cand_next = cand_new;
            if (cand_new != LIT_NONE) begin
              lit_cnt_next = 3'd1;
              value_size_next = pos_t'(1);
              phase_next = PH_IN_LITERAL;
            end else begin
              lit_cnt_next = '0;
              if (is_term) begin
                value_size_next = '0;
                pair_hit = 1'b1;
                phase_next = PH_SEEK_KEY;
              end else begin
                value_size_next = sat_inc('0);
                phase_next = PH_IN_BARE;
              end
            end
          end
        end
        PH_IN_QUOTED: begin
          if (text_byte == CH_QUOTE) begin
            pair_hit = 1'b1;
            pair_quoted = 1'b1;
            phase_next = PH_SEEK_KEY;
          end else begin
            if (value_size == '0) begin
              first_char_next = text_byte;
              lit_cand_next = cand_new;
              lit_cnt_next = (cand_new != LIT_NONE) ? 3'd1 : 3'd0;
            end else if (lit_ok) begin
              lit_cnt_next = lit_cnt + 3'd1;
            end else begin
              lit_cand_next = LIT_NONE;
              lit_cnt_next = '0;
            end
            value_size_next = sat_inc(value_size);
          end
        end
        PH_IN_LITERAL: begin
          if (lit_ok) begin
            lit_cnt_next = lit_cnt + 3'd1;
            value_size_next = sat_inc(value_size);
            if (lit_cnt + 3'd1 == lit_len(lit_cand)) begin
              pair_hit = 1'b1;
              phase_next = PH_SEEK_KEY;
            end
          end else begin
            lit_cand_next = LIT_NONE;
            lit_cnt_next = '0;
            if (is_term) begin
              pair_hit = 1'b1;
              phase_next = PH_SEEK_KEY;
            end else begin
              value_size_next = sat_inc(value_size);
              phase_next = PH_IN_BARE;
            end
          end
        end
        PH_IN_BARE: begin
          if (is_term) begin
            pair_hit = 1'b1;
            phase_next = PH_SEEK_KEY;
          end else begin
            value_size_next = sat_inc(value_size);
          end
        end
        default: begin
          phase_next = PH_SEEK_KEY;
          if (text_byte == CH_QUOTE && pairs_seen < max_pairs) begin
            key_start_next = sat_inc(byte_position);
            key_size_next = '0;
            phase_next = PH_IN_KEY;
          end
        end
      endcase
    end
  end

  always_comb begin
    pairs_emit = pairs_seen;
    if (pair_hit && pairs_seen != COUNT_MAX) begin
      pairs_emit = pairs_seen + count_t'(1);
    end

    pair_rec.record_kind = RK_PAIR;
    pair_rec.key_offset = key_start;
    pair_rec.key_length = key_size;
    pair_rec.value_offset = value_start_next;
    pair_rec.value_length = value_size_next;
    pair_rec.value_type = value_kind(lit_cand_next, lit_cnt_next, value_size_next,
                                     first_char_next, pair_quoted);
    pair_rec.pair_count = pairs_emit;
    pair_rec.last = !end_doc;

    sum_rec.record_kind = RK_SUMMARY;
    sum_rec.key_offset = '0;
    sum_rec.key_length = '0;
    sum_rec.value_offset = '0;
    sum_rec.value_length = '0;
    sum_rec.value_type = VT_NULL;
    sum_rec.pair_count = pairs_emit;
    sum_rec.last = 1'b1;

    emit.rec_a = (pair_hit || !end_doc) ? pair_rec : sum_rec;
    emit.rec_b = sum_rec;
    if (!accept) begin
      emit.n = 2'd0;
    end else if (end_doc) begin
      emit.n = pair_hit ? 2'd2 : 2'd1;
    end else begin
      emit.n = pair_hit ? 2'd1 : 2'd0;
    end

    pairs_seen_next = pairs_emit;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_pairs <= MAX_PAIRS_RESET;
      phase <= PH_SEEK_KEY;
      byte_position <= '0;
      key_start <= '0;
      key_size <= '0;
      value_start <= '0;
      value_size <= '0;
      lit_cand <= LIT_NONE;
      lit_cnt <= '0;
      first_char <= CH_NUL;
      pairs_seen <= '0;
    end else begin
      if (cfg_we) begin
        max_pairs <= cfg_data;
      end
      if (accept) begin
        if (end_doc) begin
          phase <= PH_SEEK_KEY;
          byte_position <= '0;
          key_start <= '0;
          key_size <= '0;
          value_start <= '0;
          value_size <= '0;
          lit_cand <= LIT_NONE;
          lit_cnt <= '0;
          first_char <= CH_NUL;
          pairs_seen <= '0;
        end else begin
          phase <= phase_next;
          byte_position <= byte_position_next;
          key_start <= key_start_next;
          key_size <= key_size_next;
          value_start <= value_start_next;
          value_size <= value_size_next;
          lit_cand <= lit_cand_next;
          lit_cnt <= lit_cnt_next;
          first_char <= first_char_next;
          pairs_seen <= pairs_seen_next;
        end
      end
    end
  end

endmodule

@@ sv/jps_queue.sv @@
// Small record queue: takes up to two words per cycle, hands out one.
// Depends on jps_pkg.
module jps_queue (
  input  logic                                   clk,
  input  logic                                   rst,
  input  jps_pkg::scan_out_t                     push,
  input  logic                                   pop,
  output jps_pkg::record_t                       head,
  output logic [$clog2(jps_pkg::QUEUE_DEPTH+1)-1:0] level
);
  import jps_pkg::*;

  localparam int PtrW = $clog2(QUEUE_DEPTH);
  localparam int LvlW = $clog2(QUEUE_DEPTH + 1);

  record_t         mem [QUEUE_DEPTH];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [PtrW-1:0] wr_ptr_b;

  assign wr_ptr_b = wr_ptr + PtrW'(1);
  assign head = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push.n != 2'd0) begin
      mem[wr_ptr] <= push.rec_a;
    end
    if (push.n == 2'd2) begin
      mem[wr_ptr_b] <= push.rec_b;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level <= '0;
    end else begin
      wr_ptr <= wr_ptr + PtrW'(push.n);
      if (pop) begin
        rd_ptr <= rd_ptr + PtrW'(1);
      end
      level <= level + LvlW'(push.n) - LvlW'(pop);
    end
  end

endmodule

@@ sv/json_pair_scanner_top.sv @@
// Takes one text byte per cycle and delivers one word per key/value pair, plus one
// summary word when a zero byte ends the document. Each accepted byte is scanned in
// the cycle it arrives, and its words (at most two) go into a four-word queue that
// drives the result channel. text.ready stays high while the queue has room for two
// words, so a steady stream runs at one byte per cycle as long as results are taken.
// The user must write max_pairs through cfg_we/cfg_data only while the block is idle;
// the block itself does not enforce this. max_pairs resets to 16.
// Top level; depends on jps_pkg, jps_if, jps_scan and jps_queue.
module json_pair_scanner_top #(
  parameter int MAX_DOC_BYTES = jps_pkg::DEF_MAX_DOC_BYTES
) (
  input  logic                clk,
  input  logic                rst,
  jps_text_if.sink            text,
  jps_record_if.source        result,
  input  logic                cfg_we,
  input  jps_pkg::count_t     cfg_data
);
  import jps_pkg::*;

  localparam int LvlW = $clog2(QUEUE_DEPTH + 1);

  scan_out_t       emit;
  record_t         head;
  logic [LvlW-1:0] level;
  logic            accept;
  logic            pop;

  assign text.ready = (level <= LvlW'(QUEUE_DEPTH - 2));
  assign accept = text.valid && text.ready;
  assign result.valid = (level != '0);
  assign pop = result.valid && result.ready;

  jps_scan #(
    .MAX_DOC_BYTES(MAX_DOC_BYTES)
  ) u_scan (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .text_byte(text.text_byte),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .emit     (emit)
  );

  jps_queue u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (emit),
    .pop  (pop),
    .head (head),
    .level(level)
  );

  assign result.record_kind = head.record_kind;
  assign result.key_offset = head.key_offset;
  assign result.key_length = head.key_length;
  assign result.value_offset = head.value_offset;
  assign result.value_length = head.value_length;
  assign result.value_type = head.value_type;
  assign result.pair_count = head.pair_count;
  assign result.last = head.last;

`ifndef NO_ASSERTIONS
  a_summary_last: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.record_kind == RK_SUMMARY |-> result.last)
    else $error("summary word without last");

  a_summary_zero: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.record_kind == RK_SUMMARY |->
      result.key_offset == '0 && result.key_length == '0 && result.value_offset == '0 &&
      result.value_length == '0 && result.value_type == VT_NULL)
    else $error("summary word carries pair fields");

  a_pair_counted: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.record_kind == RK_PAIR |-> result.pair_count != '0)
    else $error("pair word with zero pair count");

  a_stall_has_output: assert property (@(posedge clk) disable iff (rst)
    !text.ready |-> result.valid)
    else $error("input stalled with empty queue");
`endif

endmodule
